// File: rtl/core/rcx_pkg.sv
package rcx_pkg;

    localparam logic [7:0] START_MARK = 8'hFE;
    localparam logic [7:0] ID_FULL    = 8'd65;
    localparam logic [7:0] ID_RAW     = 8'd35;
    localparam logic [7:0] RAW_COUNT  = 8'd8;

    localparam int STORE_DEPTH = 42;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BIDX_W      = 6;

    // Read sequence at frame end: boot time bytes, RSSI, count, then channel byte pairs
    localparam logic [BIDX_W-1:0] IDX_RSSI  = 6'd4;
    localparam logic [BIDX_W-1:0] IDX_TOTAL = 6'd5;
    localparam logic [BIDX_W-1:0] IDX_CH0   = 6'd6;

    localparam logic [ADDR_W-1:0] ADDR_TOTAL     = 6'd40;
    localparam logic [ADDR_W-1:0] ADDR_RSSI_FULL = 6'd41;
    localparam logic [ADDR_W-1:0] ADDR_RSSI_RAW  = 6'd21;

    localparam logic [4:0] FULL_CHANNELS = 5'd16;
    localparam logic [4:0] RAW_CHANNELS  = 5'd8;

    typedef struct packed {
        logic in_ready;
        logic ld_len;
        logic ld_msgid;
        logic wr_pay;
        logic clr_bidx;
        logic inc_bidx;
        logic capture;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic in_accept;
        logic is_start;
        logic len_zero;
        logic pay_done;
        logic msg_full;
        logic msg_raw;
        logic is_hi;
        logic chan_last;
        logic out_free;
    } t_sts;

    // Store address for each step of the read sequence
    function automatic logic [ADDR_W-1:0] f_rd_addr(input logic [BIDX_W-1:0] bidx,
                                                    input logic full);
        logic [ADDR_W-1:0] addr;
        if (bidx == IDX_RSSI) begin
            addr = full ? ADDR_RSSI_FULL : ADDR_RSSI_RAW;
        end else if (bidx == IDX_TOTAL) begin
            addr = ADDR_TOTAL;
        end else if (bidx < IDX_RSSI) begin
            addr = bidx[ADDR_W-1:0];
        end else begin
            addr = bidx[ADDR_W-1:0] - 6'd2;
        end
        return addr;
    endfunction

endpackage

// File: rtl/core/rcx_byte_if.sv
interface rcx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/rcx_chan_if.sv
interface rcx_chan_if;
    logic        valid;
    logic        ready;
    logic        msg_kind;
    logic [4:0]  channel_number;
    logic [15:0] channel_value;
    logic        channel_present;
    logic [7:0]  channel_total;
    logic [7:0]  signal_strength;
    logic [31:0] boot_time_ms;
    logic        last;

    modport source (output valid, output msg_kind, output channel_number,
                    output channel_value, output channel_present, output channel_total,
                    output signal_strength, output boot_time_ms, output last,
                    input ready);
    modport sink (input valid, input msg_kind, input channel_number,
                  input channel_value, input channel_present, input channel_total,
                  input signal_strength, input boot_time_ms, input last,
                  output ready);
endinterface

// File: rtl/core/mavlink_v1_rc_channel_extractor.sv
// Frame parser for a MAVLink v1 byte stream that extracts RC channel messages.
// i_rx carries one received byte per transaction; o_chan carries one channel
// result per transaction, with last set on the final channel of a frame.
// While parsing, a byte is accepted every cycle; the CRC bytes are not checked.
// After the second CRC byte of an id 65 frame, 16 results follow; of an id 35
// frame, 8 results; other frames give none. During that run i_rx is not ready.
// The run reads the payload store one byte at a time through the registered RAM
// read port, setting the address in S_RD and capturing the byte in S_CAP: first
// the header fields, then the low and high byte of each channel, with S_OUT
// loading the output register with the channel result after each high byte.
// When the receiver stalls, the current result is held in the output register
// and the run pauses; the next frame byte is taken once the run has finished.
// Reset returns the parser to waiting for a start byte and marks every payload
// store entry unwritten, so it reads as zero until a frame fills it; there is
// no clearing pass.
module mavlink_v1_rc_channel_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcx_byte_if.sink   i_rx,
    rcx_chan_if.source o_chan
);

    rcx_pkg::t_cmd cmd;
    rcx_pkg::t_sts sts;

    rcx_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_chan  (o_chan),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    rcx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

endmodule

// File: rtl/core/rcx_ram.sv
module rcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 42
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/rcx_dpath.sv
module rcx_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rcx_byte_if.sink        i_rx,
    rcx_chan_if.source      o_chan,
    input  rcx_pkg::t_cmd   i_cmd,
    output rcx_pkg::t_sts   o_sts
);

    logic [7:0]                    r_len;
    logic [7:0]                    r_pos;
    logic [7:0]                    r_msgid;
    logic [rcx_pkg::BIDX_W-1:0]    r_bidx;
    logic [rcx_pkg::STORE_DEPTH-1:0] r_valid;
    logic                          r_rdv;
    logic [31:0]                   r_boot;
    logic [7:0]                    r_rssi;
    logic [7:0]                    r_total;
    logic [7:0]                    r_lo;
    logic [7:0]                    r_hi;

    logic                          r_out_valid;
    logic                          r_out_kind;
    logic [4:0]                    r_out_num;
    logic [15:0]                   r_out_value;
    logic                          r_out_present;
    logic [7:0]                    r_out_total;
    logic [7:0]                    r_out_rssi;
    logic [31:0]                   r_out_boot;
    logic                          r_out_last;

    logic                          msg_full;
    logic                          we;
    logic [rcx_pkg::ADDR_W-1:0]    raddr;
    logic [7:0]                    ram_q;
    logic [7:0]                    rd_byte;
    logic [4:0]                    chan_num;
    logic [15:0]                   chan_val;
    logic                          out_free;

    assign msg_full = (r_msgid == rcx_pkg::ID_FULL);
    assign we       = i_cmd.wr_pay && (r_pos < 8'(rcx_pkg::STORE_DEPTH));
    assign raddr    = rcx_pkg::f_rd_addr(r_bidx, msg_full);
    // Entries never written since reset read as zero
    assign rd_byte  = r_rdv ? ram_q : 8'd0;
    assign chan_num = r_bidx[rcx_pkg::BIDX_W-1:1] - 5'd2;
    assign chan_val = {r_hi, r_lo};
    assign out_free = !r_out_valid || o_chan.ready;

    rcx_ram #(
        .WIDTH (8),
        .DEPTH (rcx_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pos[rcx_pkg::ADDR_W-1:0]),
        .i_wdata (i_rx.rx_byte),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= 8'd0;
            r_pos   <= 8'd0;
            r_msgid <= 8'd0;
            r_bidx  <= '0;
            r_valid <= '0;
            r_rdv   <= 1'b0;
        end else begin
            if (i_cmd.ld_len) begin
                r_len <= i_rx.rx_byte;
            end
            if (i_cmd.ld_msgid) begin
                r_msgid <= i_rx.rx_byte;
                r_pos   <= 8'd0;
            end else if (i_cmd.wr_pay) begin
                r_pos <= r_pos + 8'd1;
            end
            if (we) begin
                r_valid[r_pos[rcx_pkg::ADDR_W-1:0]] <= 1'b1;
            end
            if (i_cmd.clr_bidx) begin
                r_bidx <= '0;
            end else if (i_cmd.inc_bidx) begin
                r_bidx <= r_bidx + 6'd1;
            end
            r_rdv <= r_valid[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            priority if (r_bidx < rcx_pkg::IDX_RSSI) begin
                unique case (r_bidx[1:0])
                    2'd0:    r_boot[7:0]   <= rd_byte;
                    2'd1:    r_boot[15:8]  <= rd_byte;
                    2'd2:    r_boot[23:16] <= rd_byte;
                    default: r_boot[31:24] <= rd_byte;
                endcase
            end else if (r_bidx == rcx_pkg::IDX_RSSI) begin
                r_rssi <= rd_byte;
            end else if (r_bidx == rcx_pkg::IDX_TOTAL) begin
                r_total <= rd_byte;
            end else if (!r_bidx[0]) begin
                r_lo <= rd_byte;
            end else begin
                r_hi <= rd_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind    <= !msg_full;
            r_out_num     <= chan_num;
            r_out_value   <= chan_val;
            r_out_present <= msg_full ? (chan_val != 16'hFFFF) : (chan_val != 16'd0);
            r_out_total   <= msg_full ? r_total : rcx_pkg::RAW_COUNT;
            r_out_rssi    <= r_rssi;
            r_out_boot    <= r_boot;
            r_out_last    <= o_sts.chan_last;
        end
    end

    assign i_rx.ready = i_cmd.in_ready;

    assign o_chan.valid           = r_out_valid;
    assign o_chan.msg_kind        = r_out_kind;
    assign o_chan.channel_number  = r_out_num;
    assign o_chan.channel_value   = r_out_value;
    assign o_chan.channel_present = r_out_present;
    assign o_chan.channel_total   = r_out_total;
    assign o_chan.signal_strength = r_out_rssi;
    assign o_chan.boot_time_ms    = r_out_boot;
    assign o_chan.last            = r_out_last;

    assign o_sts.in_accept = i_rx.valid && i_cmd.in_ready;
    assign o_sts.is_start  = (i_rx.rx_byte == rcx_pkg::START_MARK);
    assign o_sts.len_zero  = (r_len == 8'd0);
    assign o_sts.pay_done  = (({1'b0, r_pos} + 9'd1) >= {1'b0, r_len});
    assign o_sts.msg_full  = msg_full;
    assign o_sts.msg_raw   = (r_msgid == rcx_pkg::ID_RAW);
    assign o_sts.is_hi     = r_bidx[0] && (r_bidx > rcx_pkg::IDX_CH0);
    assign o_sts.chan_last = (chan_num ==
                              (msg_full ? rcx_pkg::FULL_CHANNELS : rcx_pkg::RAW_CHANNELS));
    assign o_sts.out_free  = out_free;

endmodule

// File: rtl/core/rcx_ctrl.sv
module rcx_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rcx_pkg::t_sts   i_sts,
    output rcx_pkg::t_cmd   o_cmd
);

    typedef enum logic [11:0] {
        S_WAIT    = 12'b0000_0000_0001,
        S_LEN     = 12'b0000_0000_0010,
        S_SEQ     = 12'b0000_0000_0100,
        S_SYS     = 12'b0000_0000_1000,
        S_COMP    = 12'b0000_0001_0000,
        S_MSGID   = 12'b0000_0010_0000,
        S_PAYLOAD = 12'b0000_0100_0000,
        S_CRC1    = 12'b0000_1000_0000,
        S_CRC2    = 12'b0001_0000_0000,
        S_RD      = 12'b0010_0000_0000,
        S_CAP     = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign acc = i_sts.in_accept;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_WAIT: begin
                o_cmd.in_ready = 1'b1;
                if (acc && i_sts.is_start) n_state = S_LEN;
            end
            S_LEN: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.ld_len   = acc;
                if (acc) n_state = S_SEQ;
            end
            S_SEQ: begin
                o_cmd.in_ready = 1'b1;
                if (acc) n_state = S_SYS;
            end
            S_SYS: begin
                o_cmd.in_ready = 1'b1;
                if (acc) n_state = S_COMP;
            end
            S_COMP: begin
                o_cmd.in_ready = 1'b1;
                if (acc) n_state = S_MSGID;
            end
            S_MSGID: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.ld_msgid = acc;
                if (acc) n_state = i_sts.len_zero ? S_CRC1 : S_PAYLOAD;
            end
            S_PAYLOAD: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.wr_pay   = acc;
                if (acc && i_sts.pay_done) n_state = S_CRC1;
            end
            S_CRC1: begin
                o_cmd.in_ready = 1'b1;
                if (acc) n_state = S_CRC2;
            end
            S_CRC2: begin
                o_cmd.in_ready = 1'b1;
                if (acc) begin
                    if (i_sts.msg_full || i_sts.msg_raw) begin
                        o_cmd.clr_bidx = 1'b1;
                        n_state        = S_RD;
                    end else begin
                        n_state = S_WAIT;
                    end
                end
            end
            S_RD: begin
                n_state = S_CAP;
            end
            S_CAP: begin
                o_cmd.capture = 1'b1;
                if (i_sts.is_hi) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.inc_bidx = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_OUT: begin
                // hold until the output register can take the channel
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_sts.chan_last) begin
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.inc_bidx = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
